/* sv/separable_box_filter_rgba_top_assert.svh */
// Assertion helpers for the box filter block, clocked on i_clk, off in reset.
`ifndef SEPARABLE_BOX_FILTER_RGBA_TOP_ASSERT_SVH
`define SEPARABLE_BOX_FILTER_RGBA_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sbf_pkg.sv */
package sbf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 31;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 8;
    localparam int PIX_W     = CHANNELS * CH_W;
    localparam int SCALE_SHIFT = 15;
    localparam int DIV_ONE   = 1 << SCALE_SHIFT;
    localparam int RECIP_W   = 15;

    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 12;
    localparam int KER_W     = 5;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_COL_W = 10;
    localparam int OUT_ROW_W = 12;
    localparam int MAX_HEIGHT = 4095;

    localparam logic [IMG_W_W-1:0] RST_IMG_W = 11'd640;
    localparam logic [IMG_H_W-1:0] RST_IMG_H = 12'd480;
    localparam logic [KER_W-1:0]   RST_KER   = 5'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 2'd3;

    // tdata of a result beat: four channels, column, row, zero fill
    localparam int OUT_DATA_W = 56;

endpackage

/* sv/separable_box_filter_rgba_top.sv */
// A beat whose window is inside the image is summed in S_ROW, scaled in S_HMUL, written in
// S_WRITE, summed down the column in S_COL, scaled in S_VMUL and loaded out in S_OUT.
// The next input beat is taken only back in S_IDLE: after S_OUT for a beat with a result,
// after S_WRITE for a row-sum-only beat or one that skips S_ROW; a full output
// register holds the block in its last state until the result beat leaves.
// Reset clears counters, config (640x480, 3x3) and control; the line store is not cleared.
`include "separable_box_filter_rgba_top_assert.svh"

module separable_box_filter_rgba_top #(
    parameter int MAX_WIDTH  = sbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = sbf_pkg::DEF_MAX_KERNEL
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic [sbf_pkg::PIX_W-1:0]         s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24], column [41:32],
    // row [53:42], zeros [55:54]
    output logic [sbf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int CH    = sbf_pkg::CHANNELS;
    localparam int CW    = sbf_pkg::CH_W;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_KERNEL);
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int HSW   = $clog2(MAX_KERNEL * 255 + 1);
    localparam int PW    = HSW + sbf_pkg::RECIP_W;
    localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int YW    = sbf_pkg::IMG_H_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ROW, S_HMUL, S_WRITE, S_COL, S_VMUL, S_OUT
    } t_state;

    t_state r_state;

    logic [sbf_pkg::IMG_W_W-1:0] r_img_w;
    logic [sbf_pkg::IMG_H_W-1:0] r_img_h;
    logic [sbf_pkg::KER_W-1:0]   r_ker_w;
    logic [sbf_pkg::KER_W-1:0]   r_ker_h;

    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [SW-1:0] r_lslot;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_rslot;
    logic          r_rowok;
    logic          r_outok;
    logic          r_fend;
    logic [SW-1:0] r_idx;
    logic [KW-1:0] r_iss;
    logic          r_pend;
    logic [HSW-1:0] r_sum  [CH];
    logic [PW-1:0]  r_prod [CH];

    logic                          r_ovalid;
    logic [sbf_pkg::PIX_W-1:0]     r_opix;
    logic [sbf_pkg::OUT_COL_W-1:0] r_ocol;
    logic [sbf_pkg::OUT_ROW_W-1:0] r_orow;
    logic                          r_olast;

    // effective (clamped) configuration
    logic [XW:0]   w_w;
    logic [YW-1:0] w_h;
    logic [KW-1:0] w_kw;
    logic [KW-1:0] w_kh;

    always_comb begin
        if (r_img_w < 11'd2) begin
            w_w = (XW+1)'(2);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_w = (XW+1)'(MAX_WIDTH);
        end else begin
            w_w = (XW+1)'(r_img_w);
        end
        if (r_img_h < 12'd2) begin
            w_h = 12'd2;
        end else if (32'(r_img_h) > 32'(sbf_pkg::MAX_HEIGHT)) begin
            w_h = 12'(sbf_pkg::MAX_HEIGHT);
        end else begin
            w_h = r_img_h;
        end
        if (r_ker_w < 5'd2) begin
            w_kw = KW'(2);
        end else if (32'(r_ker_w) > 32'(MAX_KERNEL)) begin
            w_kw = KW'(MAX_KERNEL);
        end else begin
            w_kw = KW'(r_ker_w);
        end
        if (r_ker_h < 5'd2) begin
            w_kh = KW'(2);
        end else if (32'(r_ker_h) > 32'(MAX_KERNEL)) begin
            w_kh = KW'(MAX_KERNEL);
        end else begin
            w_kh = KW'(r_ker_h);
        end
    end

    // floor(32768 / k) for every box size k from 2 to MAX_KERNEL; entries 0 and 1 hold the value for 2
    logic [sbf_pkg::RECIP_W-1:0] w_recip [MAX_KERNEL + 1];

    for (genvar k = 0; k <= MAX_KERNEL; k++) begin : g_recip
        localparam int KD = (k < 2) ? 2 : k;
        localparam logic [sbf_pkg::RECIP_W-1:0] RC = sbf_pkg::RECIP_W'(sbf_pkg::DIV_ONE / KD);
        assign w_recip[k] = RC;
    end

    logic w_in_acc;
    logic w_out_load;
    logic w_col_last;
    logic w_row_last;
    logic w_rowok;
    logic w_outok;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign w_col_last    = (32'(r_col) + 32'd1) >= 32'(w_w);
    assign w_row_last    = (32'(r_row) + 32'd1) >= 32'(w_h);
    assign w_rowok       = (32'(r_col) + 32'd1) >= 32'(w_kw);
    assign w_outok       = w_rowok && ((32'(r_row) + 32'd1) >= 32'(w_kh));

    logic [sbf_pkg::PIX_W-1:0] w_tap;

    sbf_window #(
        .MAX_KERNEL (MAX_KERNEL),
        .IDX_W      (SW)
    ) u_window (
        .i_clk   (i_clk),
        .i_shift (w_in_acc),
        .i_pixel (s_axis_tdata),
        .i_idx   (r_idx),
        .o_tap   (w_tap)
    );

    // scale each product back and clamp to a byte; the row result is zero when the row window is not full
    logic [sbf_pkg::PIX_W-1:0] w_scaled;
    logic [sbf_pkg::PIX_W-1:0] w_rowres;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            if ((r_prod[c] >> sbf_pkg::SCALE_SHIFT) > PW'(255)) begin
                w_scaled[c*CW +: CW] = 8'hFF;
            end else begin
                w_scaled[c*CW +: CW] = CW'(r_prod[c] >> sbf_pkg::SCALE_SHIFT);
            end
        end
        w_rowres = r_rowok ? w_scaled : '0;
    end

    logic [SW-1:0] w_prev_slot;
    logic          w_rd;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [sbf_pkg::PIX_W-1:0] w_rdata;

    assign w_prev_slot = (r_rslot == '0) ? SW'(MAX_KERNEL - 1) : SW'(r_rslot - 1'b1);
    assign w_rd        = (r_state == S_COL) && (r_iss != w_kh);
    assign w_waddr     = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_x);
    assign w_raddr     = AW'(w_prev_slot) * AW'(MAX_WIDTH) + AW'(r_x);

    sbf_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (w_waddr),
        .i_wdata (w_rowres),
        .i_re    (w_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [sbf_pkg::RECIP_W-1:0] w_recip_kw;
    logic [sbf_pkg::RECIP_W-1:0] w_recip_kh;

    assign w_recip_kw = w_recip[w_kw];
    assign w_recip_kh = w_recip[w_kh];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_img_w  <= sbf_pkg::RST_IMG_W;
            r_img_h  <= sbf_pkg::RST_IMG_H;
            r_ker_w  <= sbf_pkg::RST_KER;
            r_ker_h  <= sbf_pkg::RST_KER;
            r_col    <= '0;
            r_row    <= '0;
            r_lslot  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbf_pkg::CFG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[sbf_pkg::IMG_W_W-1:0];
                    sbf_pkg::CFG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[sbf_pkg::IMG_H_W-1:0];
                    sbf_pkg::CFG_KERNEL_WIDTH:  r_ker_w <= i_cfg_data[sbf_pkg::KER_W-1:0];
                    sbf_pkg::CFG_KERNEL_HEIGHT: r_ker_h <= i_cfg_data[sbf_pkg::KER_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x     <= r_col;
                        r_y     <= r_row;
                        r_slot  <= r_lslot;
                        r_rowok <= w_rowok;
                        r_outok <= w_outok;
                        r_fend  <= w_col_last && w_row_last;
                        r_idx   <= '0;
                        for (int c = 0; c < CH; c++) begin
                            r_sum[c]  <= '0;
                            r_prod[c] <= '0;
                        end
                        // advance the raster position
                        if (w_col_last) begin
                            r_col <= '0;
                            if (w_row_last) begin
                                r_row   <= '0;
                                r_lslot <= '0;
                            end else begin
                                r_row   <= YW'(r_row + 1'b1);
                                r_lslot <= (r_lslot == SW'(MAX_KERNEL - 1)) ? '0
                                                                             : SW'(r_lslot + 1'b1);
                            end
                        end else begin
                            r_col <= XW'(r_col + 1'b1);
                        end
                        r_state <= w_rowok ? S_ROW : S_WRITE;
                    end
                end
                S_ROW: begin
                    for (int c = 0; c < CH; c++) begin
                        r_sum[c] <= HSW'(r_sum[c] + HSW'(w_tap[c*CW +: CW]));
                    end
                    if ((32'(r_idx) + 32'd1) == 32'(w_kw)) begin
                        r_state <= S_HMUL;
                    end else begin
                        r_idx <= SW'(r_idx + 1'b1);
                    end
                end
                S_HMUL: begin
                    for (int c = 0; c < CH; c++) begin
                        r_prod[c] <= PW'(r_sum[c]) * PW'(w_recip_kw);
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // current row result is the newest term of the column sum
                    for (int c = 0; c < CH; c++) begin
                        r_sum[c] <= HSW'(w_rowres[c*CW +: CW]);
                    end
                    r_rslot <= r_slot;
                    r_iss   <= KW'(1);
                    r_pend  <= 1'b0;
                    r_state <= r_outok ? S_COL : S_IDLE;
                end
                S_COL: begin
                    if (w_rd) begin
                        r_rslot <= w_prev_slot;
                        r_iss   <= KW'(r_iss + 1'b1);
                    end
                    r_pend <= w_rd;
                    if (r_pend) begin
                        for (int c = 0; c < CH; c++) begin
                            r_sum[c] <= HSW'(r_sum[c] + HSW'(w_rdata[c*CW +: CW]));
                        end
                    end
                    if (!w_rd && !r_pend) begin
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    for (int c = 0; c < CH; c++) begin
                        r_prod[c] <= PW'(r_sum[c]) * PW'(w_recip_kh);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (w_out_load) begin
                        r_opix   <= w_scaled;
                        r_ocol   <= sbf_pkg::OUT_COL_W'(32'(r_x) - 32'(w_kw) + 32'd1
                                                       + 32'(w_kw >> 1));
                        r_orow   <= sbf_pkg::OUT_ROW_W'(32'(r_y) - 32'(w_kh) + 32'd1
                                                       + 32'(w_kh >> 1));
                        r_olast  <= r_fend;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_orow, r_ocol, r_opix};
    assign m_axis_tlast  = r_olast;

    `SBF_ASSERT_NOW(a_ready_idle, s_axis_tready, r_state == S_IDLE, "ready outside idle")
    `SBF_ASSERT_NEXT(a_acc_busy, w_in_acc, r_state != S_IDLE, "accepted beat not started")
    `SBF_ASSERT_NEXT(a_out_load, w_out_load, m_axis_tvalid && r_state == S_IDLE,
                     "result not presented")
    `SBF_ASSERT_NOW(a_iss_bound, r_state == S_COL, r_iss <= w_kh, "column reads overrun")

endmodule

/* sv/sbf_window.sv */
module sbf_window #(
    parameter int MAX_KERNEL = sbf_pkg::DEF_MAX_KERNEL,
    parameter int IDX_W      = $clog2(MAX_KERNEL)
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [sbf_pkg::PIX_W-1:0]  i_pixel,
    input  logic [IDX_W-1:0]           i_idx,
    output logic [sbf_pkg::PIX_W-1:0]  o_tap
);

    // newest pixel at tap 0
    logic [sbf_pkg::PIX_W-1:0] r_taps [MAX_KERNEL];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_taps[0] <= i_pixel;
            for (int i = 1; i < MAX_KERNEL; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    assign o_tap = r_taps[i_idx];

endmodule

/* sv/sbf_line_mem.sv */
module sbf_line_mem #(
    parameter int DEPTH = sbf_pkg::DEF_MAX_KERNEL * sbf_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [sbf_pkg::PIX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [sbf_pkg::PIX_W-1:0]  o_rdata
);

    logic [sbf_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [sbf_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
